FILE: src/qau_pkg.sv
// qau_pkg: shared types and constants of the quaternion arithmetic unit
// no dependencies
`default_nettype none
package qau_pkg;
  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  typedef enum logic [2:0] {
    ACT_LOAD  = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_SUB   = 3'd2,
    ACT_SCALE = 3'd3,
    ACT_CONJ  = 3'd4,
    ACT_NORM  = 3'd5,
    ACT_MUL   = 3'd6,
    ACT_NONE  = 3'd7
  } action_t;

  // datapath commands from the controller
  typedef struct packed {
    logic    capture;   // latch input transaction
    logic    simple;    // do load/add/sub/conj/none in one step
    logic    mac;       // multiply-accumulate one product
    logic    mac_clr;   // clear accumulator
    logic    comp_done; // round, clip and store one scaled/multiplied component
    logic    sq_acc;    // accumulate one square
    logic    sqrt_init;
    logic    sqrt_step;
    logic    div_init;
    logic    div_step;
    logic    div_done;  // store one normalized component
    logic    commit;    // write results into the held quaternion
    logic [1:0] comp;   // component index
    logic [1:0] term;   // product index
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    zero;      // sum of squares is zero
  } status_t;
endpackage
`default_nettype wire

FILE: src/quaternion_arithmetic_unit.sv
// quaternion_arithmetic_unit: top level, controller plus datapath
// depends on qau_pkg, qau_ctrl, qau_datapath
`default_nettype none
// Holds one quaternion in signed fixed point (Q4.12 by default), reset to
// identity. Each input transaction applies one action: load, add, subtract,
// scale, conjugate, normalize, Hamilton product or none; the updated quaternion and
// zero_norm/saturated flags come back as one output transaction. One
// transaction is in flight at a time. Scale and multiply run through the
// single shared multiplier; normalize uses the bit-serial square root and
// divider. An output stall holds the unit until the result is taken.
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   action,
  input  wire logic signed [COMP_WIDTH-1:0] op_x,
  input  wire logic signed [COMP_WIDTH-1:0] op_y,
  input  wire logic signed [COMP_WIDTH-1:0] op_z,
  input  wire logic signed [COMP_WIDTH-1:0] op_w,
  input  wire logic signed [COMP_WIDTH-1:0] factor,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0]      res_x,
  output logic signed [COMP_WIDTH-1:0]      res_y,
  output logic signed [COMP_WIDTH-1:0]      res_z,
  output logic signed [COMP_WIDTH-1:0]      res_w,
  output logic                              zero_norm,
  output logic                              saturated
);
  cmd_t    cmd;
  status_t status;

  // sequencer
  qau_ctrl #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .status, .cmd
  );

  // arithmetic
  qau_datapath #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .status, .action, .op_x, .op_y, .op_z, .op_w, .factor,
    .res_x, .res_y, .res_z, .res_w, .zero_norm, .saturated
  );
endmodule
`default_nettype wire

FILE: src/qau_datapath.sv
// qau_datapath: quaternion registers, one shared multiplier, sqrt and divider units
// depends on qau_pkg
`default_nettype none
module qau_datapath import qau_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cmd_t                         cmd,
  output status_t                           status,
  input  wire logic [2:0]                   action,
  input  wire logic signed [COMP_WIDTH-1:0] op_x,
  input  wire logic signed [COMP_WIDTH-1:0] op_y,
  input  wire logic signed [COMP_WIDTH-1:0] op_z,
  input  wire logic signed [COMP_WIDTH-1:0] op_w,
  input  wire logic signed [COMP_WIDTH-1:0] factor,
  output logic signed [COMP_WIDTH-1:0]      res_x,
  output logic signed [COMP_WIDTH-1:0]      res_y,
  output logic signed [COMP_WIDTH-1:0]      res_z,
  output logic signed [COMP_WIDTH-1:0]      res_w,
  output logic                              zero_norm,
  output logic                              saturated
);
  localparam int CW  = COMP_WIDTH;
  localparam int PW  = 2 * CW;
  localparam int AW  = PW + 3;       // sum of four products
  localparam int SW  = PW + 3;       // sum of four squares
  localparam int NW  = (SW + 1) / 2; // square root width
  localparam int DW  = CW + FRAC_BITS + 1; // dividend width
  localparam logic signed [AW-1:0] CMAXA = AW'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [AW-1:0] CMINA = -AW'(64'sd1 <<< (CW - 1));
  localparam logic [SW+63:0] SQ_MAX = (SW+64)'(64'hFFFF_FFFF_FFFF_FFFF);

  logic signed [CW-1:0] q [4];
  logic signed [CW-1:0] o [4];
  logic signed [CW-1:0] r [4];
  logic signed [CW-1:0] fac;
  action_t act;
  logic sat, zflag;

  // product selection for the hamilton product
  logic signed [CW-1:0] ma, mb;
  logic neg;
  always_comb begin
    ma = q[cmd.comp];
    mb = fac;
    neg = 1'b0;
    if (act == ACT_MUL) begin
      case ({cmd.comp, cmd.term})
        4'h0: begin ma = q[3]; mb = o[0]; end
        4'h1: begin ma = q[0]; mb = o[3]; end
        4'h2: begin ma = q[1]; mb = o[2]; end
        4'h3: begin ma = q[2]; mb = o[1]; neg = 1'b1; end
        4'h4: begin ma = q[3]; mb = o[1]; end
        4'h5: begin ma = q[0]; mb = o[2]; neg = 1'b1; end
        4'h6: begin ma = q[1]; mb = o[3]; end
        4'h7: begin ma = q[2]; mb = o[0]; end
        4'h8: begin ma = q[3]; mb = o[2]; end
        4'h9: begin ma = q[0]; mb = o[1]; end
        4'ha: begin ma = q[1]; mb = o[0]; neg = 1'b1; end
        4'hb: begin ma = q[2]; mb = o[3]; end
        4'hc: begin ma = q[3]; mb = o[3]; end
        4'hd: begin ma = q[0]; mb = o[0]; neg = 1'b1; end
        4'he: begin ma = q[1]; mb = o[1]; neg = 1'b1; end
        default: begin ma = q[2]; mb = o[2]; neg = 1'b1; end
      endcase
    end else if (act == ACT_NORM) begin
      ma = q[cmd.term];
      mb = q[cmd.term];
    end
  end

  logic signed [PW-1:0] prod;
  logic                 prod_neg;
  logic signed [AW-1:0] acc;
  always_ff @(posedge clk) begin
    prod     <= ma * mb;
    prod_neg <= neg;
  end

  // rounded sum: floor((acc + half) / 2^F)
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] acc_in;
  assign acc_in = prod_neg ? acc - AW'(prod) : acc + AW'(prod);
  assign rnd = (acc + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  function automatic logic signed [CW-1:0] clipv(input logic signed [AW-1:0] v,
                                                 output logic s);
    s = 1'b0;
    if (v > CMAXA) begin s = 1'b1; return CW'(CMAXA); end
    if (v < CMINA) begin s = 1'b1; return CW'(CMINA); end
    return CW'(v);
  endfunction

  // sqrt (restoring, two bits per step)
  logic [SW-1:0] sq_sum, srem, sq_lim;
  logic [SW+1:0] sres, sbit;
  logic [NW-1:0] nroot;
  logic [SW+1:0] strial;
  assign strial = sres + sbit;
  assign nroot  = NW'(sres);
  // sum of squares saturates at 2^64-1, only reachable with components of 32 bits or more
  assign sq_lim = ((SW+64)'(sq_sum) > SQ_MAX) ? SW'(SQ_MAX) : sq_sum;

  // divider: q = (2*mag*2^F + n) / (2n), restoring, one quotient bit per step
  logic [DW:0]   dnum;
  logic [DW:0]   dmag;
  logic [NW+1:0] drem;
  logic [NW+1:0] dtrial;
  logic          dneg;
  assign dtrial = {drem[NW:0], dnum[DW]};
  assign dmag = (q[cmd.comp] < 0) ? (DW+1)'(-AW'(q[cmd.comp])) : (DW+1)'(q[cmd.comp]);

  logic signed [AW-1:0] s_res, d_res;
  logic signed [CW-1:0] s_clip, d_clip;
  logic s_sat, d_sat;
  always_comb begin
    s_res = rnd;
    d_res = dneg ? -AW'(signed'({1'b0, dnum})) : AW'(signed'({1'b0, dnum}));
    s_clip = clipv(s_res, s_sat);
    d_clip = clipv(d_res, d_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q[0] <= '0; q[1] <= '0; q[2] <= '0;
      q[3] <= CW'(64'sd1 <<< FRAC_BITS);
    end else begin
      if (cmd.capture) begin
        act <= action_t'(action);
        o[0] <= op_x; o[1] <= op_y; o[2] <= op_z; o[3] <= op_w;
        fac <= factor;
        sat <= 1'b0; zflag <= 1'b0;
        acc <= '0; sq_sum <= '0;
        for (int i = 0; i < 4; i++) r[i] <= q[i];
      end
      if (cmd.simple) begin
        for (int i = 0; i < 4; i++) begin
          logic s;
          logic signed [AW-1:0] v;
          s = 1'b0;
          v = '0;
          case (act)
            ACT_LOAD: r[i] <= o[i];
            ACT_ADD: begin
              v = AW'(q[i]) + AW'(o[i]);
              r[i] <= clipv(v, s); if (s) sat <= 1'b1;
            end
            ACT_SUB: begin
              v = AW'(q[i]) - AW'(o[i]);
              r[i] <= clipv(v, s); if (s) sat <= 1'b1;
            end
            ACT_CONJ: begin
              if (i < 3) begin
                v = -AW'(q[i]);
                r[i] <= clipv(v, s); if (s) sat <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      if (cmd.mac_clr) acc <= '0;
      else if (cmd.mac) acc <= acc_in;
      if (cmd.sq_acc) sq_sum <= sq_sum + SW'(unsigned'(prod));
      if (cmd.comp_done) begin
        r[cmd.comp] <= s_clip;
        if (s_sat) sat <= 1'b1;
      end
      if (cmd.sqrt_init) begin
        zflag <= (sq_sum == '0);
        srem <= sq_lim;
        sres <= '0;
        sbit <= (SW+2)'(1) << (2 * ((SW + 1) / 2) - 2);
      end
      if (cmd.sqrt_step && sbit != '0) begin
        if ((SW+2)'(srem) >= strial) begin
          srem <= SW'((SW+2)'(srem) - strial);
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      if (cmd.div_init) begin
        dneg <= q[cmd.comp] < 0;
        dnum <= (dmag << (FRAC_BITS + 1)) + (DW+1)'(nroot);
        drem <= '0;
      end
      if (cmd.div_step) begin
        if (dtrial >= {nroot, 1'b0}) begin
          drem <= dtrial - {nroot, 1'b0};
          dnum <= {dnum[DW-1:0], 1'b1};
        end else begin
          drem <= dtrial;
          dnum <= {dnum[DW-1:0], 1'b0};
        end
      end
      if (cmd.div_done) begin
        r[cmd.comp] <= d_clip;
        if (d_sat) sat <= 1'b1;
      end
      if (cmd.commit && !(act == ACT_NORM && zflag)) begin
        for (int i = 0; i < 4; i++) q[i] <= r[i];
      end
    end
  end

  assign status.action = act;
  assign status.zero   = zflag;
  assign res_x = r[0];
  assign res_y = r[1];
  assign res_z = r[2];
  assign res_w = r[3];
  assign zero_norm = zflag;
  assign saturated = sat;
endmodule
`default_nettype wire

FILE: src/qau_ctrl.sv
// qau_ctrl: sequencer of the quaternion arithmetic unit
// depends on qau_pkg
`default_nettype none
module qau_ctrl import qau_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);
  localparam int SW = 2 * COMP_WIDTH + 3;
  localparam int SQ_STEPS  = (SW + 1) / 2;
  localparam int DIV_STEPS = COMP_WIDTH + FRAC_BITS + 2;
  localparam int CNTW = $clog2(SQ_STEPS + DIV_STEPS + 8);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_MAC   = 8'b0000_0100,
    S_SQ    = 8'b0000_1000,
    S_SQRT  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_COMIT = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [1:0] comp, comp_next, term, term_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [1:0] lat, lat_next; // multiplier pipe phase

  always_comb begin
    cmd = '0;
    cmd.comp = comp;
    cmd.term = term;
    state_next = state;
    comp_next = comp; term_next = term; cnt_next = cnt; lat_next = lat;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DISP;
          comp_next = '0; term_next = '0; lat_next = '0; cnt_next = '0;
        end
      end
      S_DISP: begin
        case (status.action)
          ACT_SCALE, ACT_MUL: state_next = S_MAC;
          ACT_NORM: state_next = S_SQ;
          default: begin cmd.simple = 1'b1; state_next = S_COMIT; end
        endcase
      end
      S_MAC: begin
        // product registered the cycle after selection; lat 0 first issue,
        // 3 issue and accumulate, 1 accumulate last, 2 store component
        if (lat == 2'd1) begin
          cmd.mac = 1'b1;
          lat_next = 2'd2;
        end else if (lat == 2'd2) begin
          cmd.comp_done = 1'b1;
          cmd.mac_clr = 1'b1;
          term_next = '0; lat_next = '0;
          comp_next = comp + 2'd1;
          if (comp == 2'd3) state_next = S_COMIT;
        end else begin
          cmd.mac = (lat == 2'd3);
          if (status.action == ACT_SCALE || term == 2'd3) begin
            lat_next = 2'd1;
          end else begin
            term_next = term + 2'd1;
            lat_next = 2'd3;
          end
        end
      end
      S_SQ: begin
        if (lat == 2'd0) begin
          term_next = 2'd1;
          lat_next = 2'd1;
        end else if (lat == 2'd1) begin
          cmd.sq_acc = 1'b1;
          if (term == 2'd3) lat_next = 2'd2;
          else term_next = term + 2'd1;
        end else begin
          cmd.sq_acc = 1'b1;
          state_next = S_SQRT; cnt_next = '0;
          term_next = '0; lat_next = '0;
        end
      end
      S_SQRT: begin
        if (cnt == '0) cmd.sqrt_init = 1'b1;
        else cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(SQ_STEPS)) begin
          if (status.zero) state_next = S_COMIT;
          else begin state_next = S_DIV; cnt_next = '0; comp_next = '0; end
        end
      end
      S_DIV: begin
        if (cnt == '0) cmd.div_init = 1'b1;
        else if (cnt == CNTW'(DIV_STEPS + 1)) cmd.div_done = 1'b1;
        else cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(DIV_STEPS + 1)) begin
          cnt_next = '0;
          comp_next = comp + 2'd1;
          if (comp == 2'd3) state_next = S_COMIT;
        end
      end
      S_COMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      comp <= '0; term <= '0; cnt <= '0; lat <= '0;
    end else begin
      state <= state_next;
      comp <= comp_next; term <= term_next; cnt <= cnt_next; lat <= lat_next;
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb_quaternion_arithmetic_unit.sv
// tb_quaternion_arithmetic_unit: self-checking testbench of the quaternion arithmetic unit
// depends on qau_pkg and quaternion_arithmetic_unit; a predictor in this file holds
// its own quaternion and checks every output transaction in order
`timescale 1ns / 1ps
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam int CW = COMP_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam logic signed [CW-1:0] ONE = 1 << FB;

  typedef logic signed [CW-1:0] comp_t;

  // one input transaction plus the sender's gap before it
  typedef struct {
    action_t act;
    comp_t   x, y, z, w, f;
    int      gap;
    bit      drain;   // hold off until every expected result is back
  } cmd_item_t;

  typedef struct {
    comp_t x, y, z, w;
    logic  zn, sat;
  } quat_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  comp_t op_x = '0, op_y = '0, op_z = '0, op_w = '0, factor = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  comp_t res_x, res_y, res_z, res_w;
  logic zero_norm, saturated;

  cmd_item_t pending_cmds[$];
  quat_res_t expected_quats[$];
  int        err_count = 0;

  // predictor copy of the held quaternion
  comp_t hx, hy, hz, hw;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .op_x(op_x), .op_y(op_y), .op_z(op_z), .op_w(op_w),
    .factor(factor),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_x(res_x), .res_y(res_y), .res_z(res_z), .res_w(res_w),
    .zero_norm(zero_norm), .saturated(saturated)
  );

  function automatic comp_t clip(longint v, ref bit s);
    if (v > CMAX) begin
      s = 1'b1;
      return comp_t'(CMAX);
    end
    if (v < CMIN) begin
      s = 1'b1;
      return comp_t'(CMIN);
    end
    return comp_t'(v);
  endfunction

  // exact sum of products, rounded to nearest with ties toward plus infinity
  function automatic longint round_prod(longint sum);
    return (sum + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint norm_comp(longint c, longint n);
    longint mag;
    longint q;
    mag = (c < 0 ? -c : c) <<< FB;
    q = (2 * mag + n) / (2 * n);
    return c < 0 ? -q : q;
  endfunction

  // applies one action to the held quaternion and returns the expected result
  function automatic quat_res_t apply_action(cmd_item_t c);
    quat_res_t r;
    bit s;
    longint x, y, z, w, ox, oy, oz, ow, f, sq, n;
    s = 1'b0;
    x = hx; y = hy; z = hz; w = hw;
    ox = c.x; oy = c.y; oz = c.z; ow = c.w; f = c.f;
    r.zn = 1'b0;
    r.x = hx; r.y = hy; r.z = hz; r.w = hw;
    case (c.act)
      ACT_LOAD: begin
        r.x = c.x; r.y = c.y; r.z = c.z; r.w = c.w;
      end
      ACT_ADD: begin
        r.x = clip(x + ox, s); r.y = clip(y + oy, s);
        r.z = clip(z + oz, s); r.w = clip(w + ow, s);
      end
      ACT_SUB: begin
        r.x = clip(x - ox, s); r.y = clip(y - oy, s);
        r.z = clip(z - oz, s); r.w = clip(w - ow, s);
      end
      ACT_SCALE: begin
        r.x = clip(round_prod(x * f), s); r.y = clip(round_prod(y * f), s);
        r.z = clip(round_prod(z * f), s); r.w = clip(round_prod(w * f), s);
      end
      ACT_CONJ: begin
        r.x = clip(-x, s); r.y = clip(-y, s); r.z = clip(-z, s);
      end
      ACT_NORM: begin
        sq = x * x + y * y + z * z + w * w;
        if (sq == 0) begin
          r.zn = 1'b1;
        end else begin
          n = 0;
          for (int b = 17; b >= 0; b--) begin
            if ((n + (64'sd1 <<< b)) * (n + (64'sd1 <<< b)) <= sq) n += 64'sd1 <<< b;
          end
          r.x = clip(norm_comp(x, n), s); r.y = clip(norm_comp(y, n), s);
          r.z = clip(norm_comp(z, n), s); r.w = clip(norm_comp(w, n), s);
        end
      end
      ACT_MUL: begin
        // held * operand, all terms from the old components
        r.x = clip(round_prod(w * ox + x * ow + y * oz - z * oy), s);
        r.y = clip(round_prod(w * oy - x * oz + y * ow + z * ox), s);
        r.z = clip(round_prod(w * oz + x * oy - y * ox + z * ow), s);
        r.w = clip(round_prod(w * ow - x * ox - y * oy - z * oz), s);
      end
      default: ;
    endcase
    r.sat = s;
    hx = r.x; hy = r.y; hz = r.z; hw = r.w;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // driver: one transaction at a time from the pending queue
  int send_hold = 0;
  always @(posedge clk) begin
    bit busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        expected_quats.push_back(apply_action(pending_cmds.pop_front()));
        busy = 1'b0;
        if (pending_cmds.size() > 0) send_hold = pending_cmds[0].gap;
      end
      if (!busy) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && expected_quats.size() > 0)) begin
          action   <= pending_cmds[0].act;
          op_x     <= pending_cmds[0].x;
          op_y     <= pending_cmds[0].y;
          op_z     <= pending_cmds[0].z;
          op_w     <= pending_cmds[0].w;
          factor   <= pending_cmds[0].f;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall per result, with calm stretches of no stall
  int  recv_hold = 0;
  bit  recv_calm = 1'b0;
  always @(posedge clk) begin
    quat_res_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          e = expected_quats.pop_front();
          if (res_x !== e.x) report_mismatch("res_x", res_x, e.x);
          if (res_y !== e.y) report_mismatch("res_y", res_y, e.y);
          if (res_z !== e.z) report_mismatch("res_z", res_z, e.z);
          if (res_w !== e.w) report_mismatch("res_w", res_w, e.w);
          if (zero_norm !== e.zn) report_mismatch("zero_norm", zero_norm, e.zn);
          if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
        end
        if ($urandom_range(0, 24) == 0) recv_calm = !recv_calm;
        recv_hold = recv_calm ? 0 : $urandom_range(0, 8);
        out_stall <= (recv_hold > 0);
      end else if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= (recv_hold > 0);
      end
    end
  end

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0, 1: return comp_t'($urandom);
      2:    return comp_t'($urandom_range(0, 8192)) - comp_t'(4096);
      3:    return $urandom_range(0, 1) ? comp_t'(CMAX) : comp_t'(CMIN);
      4:    return $urandom_range(0, 1) ? ONE : -ONE;
      default: return comp_t'($urandom_range(0, 64)) - comp_t'(32);
    endcase
  endfunction

  bit sender_calm = 1'b0;
  task automatic queue_cmd(action_t a, comp_t x, comp_t y, comp_t z, comp_t w, comp_t f,
                           bit drain = 1'b0);
    cmd_item_t c;
    if ($urandom_range(0, 30) == 0) sender_calm = !sender_calm;
    c.act = a; c.x = x; c.y = y; c.z = z; c.w = w; c.f = f;
    c.gap = sender_calm ? 0 : $urandom_range(0, 8);
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  initial begin
    action_t a;
    hx = '0; hy = '0; hz = '0; hw = ONE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset identity, extremes, saturation, zero length, unused code
    queue_cmd(ACT_NONE, '0, '0, '0, '0, '0);
    queue_cmd(ACT_NORM, '0, '0, '0, '0, '0);
    queue_cmd(ACT_MUL, ONE, ONE, ONE, ONE, '0);
    queue_cmd(ACT_LOAD, comp_t'(CMAX), comp_t'(CMAX), comp_t'(CMAX), comp_t'(CMAX), '0);
    queue_cmd(ACT_ADD, comp_t'(CMAX), 16'sd1, '0, comp_t'(CMIN), '0);
    queue_cmd(ACT_SCALE, '0, '0, '0, '0, comp_t'(CMAX));
    queue_cmd(ACT_NORM, '0, '0, '0, '0, '0);
    queue_cmd(ACT_LOAD, comp_t'(CMIN), comp_t'(CMIN), comp_t'(CMIN), comp_t'(CMIN), '0);
    queue_cmd(ACT_CONJ, '0, '0, '0, '0, '0);
    queue_cmd(ACT_LOAD, comp_t'(CMIN), comp_t'(CMIN), comp_t'(CMIN), comp_t'(CMIN), '0);
    queue_cmd(ACT_SCALE, '0, '0, '0, '0, comp_t'(CMIN));
    queue_cmd(ACT_SUB, comp_t'(CMAX), comp_t'(CMIN), '0, 16'sd1, '0);
    queue_cmd(ACT_NORM, '0, '0, '0, '0, '0);
    queue_cmd(ACT_LOAD, '0, '0, '0, '0, '0, 1'b1);
    queue_cmd(ACT_NORM, '0, '0, '0, '0, '0);
    queue_cmd(ACT_MUL, comp_t'(CMIN), comp_t'(CMAX), comp_t'(CMIN), comp_t'(CMAX), '0);
    queue_cmd(ACT_LOAD, comp_t'(CMIN), comp_t'(CMAX), comp_t'(CMIN), comp_t'(CMAX), '0);
    queue_cmd(ACT_MUL, comp_t'(CMIN), comp_t'(CMIN), comp_t'(CMIN), comp_t'(CMIN), '0);
    queue_cmd(ACT_LOAD, 16'sd1, -16'sd1, 16'sd3, 16'sd0, '0);
    queue_cmd(ACT_NORM, '0, '0, '0, '0, '0);
    queue_cmd(ACT_SCALE, '0, '0, '0, '0, 16'sd1);
    queue_cmd(ACT_NONE, comp_t'(CMAX), comp_t'(CMIN), '1, '1, '1, 1'b1);

    // random: mostly a load followed by a short chain of operations
    while (pending_cmds.size() < 1420) begin
      queue_cmd(ACT_LOAD, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                $urandom_range(0, 60) == 0);
      repeat ($urandom_range(1, 6)) begin
        a = action_t'($urandom_range(0, 7));
        queue_cmd(a, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end

    wait (pending_cmds.size() == 0 && !in_valid && expected_quats.size() == 0);
    repeat (400) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
